[rtl/ppg_hrd_pkg.sv]
// ----------------------------------------------------------------------------
// ppg_hrd_pkg
// Shared widths, reset values, codes and helpers of the PPG heart-rate
// detector.
// ----------------------------------------------------------------------------
package ppg_hrd_pkg;

  localparam int unsigned Q_W        = 48;  // Q23.24 filter word
  localparam int unsigned ALPHA_W    = 24;  // Q0.24 coefficient
  localparam int unsigned FRAC_W     = 24;
  localparam int unsigned DIFF_W     = Q_W + 1;
  localparam int unsigned LO_W       = 25;  // low slice of the difference
  localparam int unsigned ACC_W      = DIFF_W + ALPHA_W + 1;
  localparam int unsigned SUM_W      = Q_W + 3;
  localparam int unsigned IVL_W      = 12;
  localparam int unsigned NUM_W      = 18;
  localparam int unsigned RATE_W     = 10;
  localparam int unsigned IDX_W      = 32;  // sample counter
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned OUT_W      = 64;
  localparam int unsigned USER_W     = 2;

  localparam int unsigned INTERVAL_DEPTH_DEF = 8;
  localparam int unsigned SAMPLE_BITS_DEF    = 18;

  localparam logic [RATE_W-1:0]  RATE_MAX         = 10'd1023;
  localparam logic [ALPHA_W-1:0] DC_ALPHA_RST     = 24'd838861;
  localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST   = 24'd671089;
  localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST   = 24'd168;
  localparam logic [ALPHA_W-1:0] SMOOTH_ALPHA_RST = 24'd1677722;
  localparam logic [ALPHA_W-1:0] NOISE_ALPHA_RST  = 24'd838861;
  localparam logic [IVL_W-1:0]   IVL_MIN_RST      = 12'd30;
  localparam logic [IVL_W-1:0]   IVL_MAX_RST      = 12'd150;
  localparam logic [NUM_W-1:0]   BEATS_NUM_RST    = 18'd6000;
  localparam logic [Q_W-1:0]     NOISE_RST        = 48'h000001000000;
  localparam logic [Q_W-1:0]     Q_POS_MAX        = 48'h7FFFFFFFFFFF;
  localparam logic [Q_W-1:0]     Q_NEG_MAX        = 48'h800000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC_ALPHA     = 3'd0,
    CFG_FAST_ALPHA   = 3'd1,
    CFG_SLOW_ALPHA   = 3'd2,
    CFG_SMOOTH_ALPHA = 3'd3,
    CFG_NOISE_ALPHA  = 3'd4,
    CFG_IVL_MIN      = 3'd5,
    CFG_IVL_MAX      = 3'd6,
    CFG_BEATS_NUM    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EMA_DC     = 3'd0,
    EMA_FAST   = 3'd1,
    EMA_SLOW   = 3'd2,
    EMA_SMOOTH = 3'd3,
    EMA_NOISE  = 3'd4
  } ema_sel_e;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_LOAD  = 4'd1,
    CMD_DIFF  = 4'd2,
    CMD_MLO   = 4'd3,
    CMD_MHI   = 4'd4,
    CMD_WB    = 4'd5,
    CMD_AC    = 4'd6,
    CMD_BP    = 4'd7,
    CMD_PEAK  = 4'd8,
    CMD_CAND  = 4'd9,
    CMD_CMP   = 4'd10,
    CMD_CHECK = 4'd11,
    CMD_DIV   = 4'd12,
    CMD_OUT   = 4'd13
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e  op;
    ema_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic beat;      // peak with an accepted interval, valid in the peak step
    logic j_last;    // scan at last ring entry
    logic found;     // candidate is the upper median
    logic med_zero;
    logic div_done;
    logic out_free;  // output register can take a result
  } status_t;

  function automatic logic [Q_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = {{(SUM_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
    lo_lim = {{(SUM_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
    if (v > hi_lim) begin
      return Q_POS_MAX;
    end else if (v < lo_lim) begin
      return Q_NEG_MAX;
    end
    return v[Q_W-1:0];
  endfunction

endpackage

[rtl/ppg_heart_rate_detector.sv]
// ----------------------------------------------------------------------------
// ppg_heart_rate_detector
// PPG beat detector: EMA filter chain, thresholded peak picking, median
// beat interval and beats-per-minute division.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tdata: ir_sample
//  m_axis   | out       | m_axis_tvalid/tready   | tdata: rate_bpm, smoothed_level
//           |           |                        | tuser: peak_seen, beat_valid
//  cfg      | in        | cfg_valid_i/cfg_ready_o| index 0..7, data up to 24 bits
//
//  One sample at a time. A sample without a beat runs through five EMAs of
//  four steps each on one shared EMA unit, plus the AC, band-pass and peak
//  steps. A beat adds the median scan over the filled ring entries and the
//  bit-serial divider.
//  Reset clears all filter state and the interval ring at once; no sweep.
//  A result waits in the output register; the next sample is taken meanwhile
//  and only its final write stalls while the old result is not yet taken.
//  cfg_ready_o is always high.
//
module ppg_heart_rate_detector #(
  parameter int unsigned INTERVAL_DEPTH = ppg_hrd_pkg::INTERVAL_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS    = ppg_hrd_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned IN_W          = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample request
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [IN_W-1:0]                    s_axis_tdata,   // [SAMPLE_BITS-1:0] ir_sample
  // result
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ppg_hrd_pkg::OUT_W-1:0]      m_axis_tdata,   // [9:0] rate_bpm,
                                                             // [57:10] smoothed_level
  output logic [ppg_hrd_pkg::USER_W-1:0]     m_axis_tuser,   // [0] peak_seen,
                                                             // [1] beat_valid
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppg_hrd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppg_hrd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ppg_hrd_pkg::cmd_t    cmd;
  ppg_hrd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  ppg_hrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppg_hrd_dp #(
    .INTERVAL_DEPTH (INTERVAL_DEPTH),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

[rtl/ppg_hrd_div.sv]
// ----------------------------------------------------------------------------
// ppg_hrd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppg_hrd_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ppg_hrd_pkg::NUM_W-1:0]  dividend_i,
  input  logic [ppg_hrd_pkg::IVL_W-1:0]  divisor_i,
  output logic                           done_o,
  output logic [ppg_hrd_pkg::NUM_W-1:0]  quotient_o
);

  localparam int unsigned NW  = ppg_hrd_pkg::NUM_W;
  localparam int unsigned DW  = ppg_hrd_pkg::IVL_W;
  localparam int unsigned CW  = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/ppg_hrd_dp.sv]
// ----------------------------------------------------------------------------
// ppg_hrd_dp
// Datapath: config registers, shared EMA unit, peak test, interval ring,
// median scan, divider and output register.
// ----------------------------------------------------------------------------
module ppg_hrd_dp #(
  parameter int unsigned INTERVAL_DEPTH = ppg_hrd_pkg::INTERVAL_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS    = ppg_hrd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ppg_hrd_pkg::cmd_t                    cmd_i,
  output ppg_hrd_pkg::status_t                 status_o,
  input  logic [SAMPLE_BITS-1:0]               sample_i,
  input  logic                                 cfg_we_i,
  input  logic [ppg_hrd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ppg_hrd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [ppg_hrd_pkg::OUT_W-1:0]        m_tdata_o,
  output logic [ppg_hrd_pkg::USER_W-1:0]       m_tuser_o
);

  localparam int unsigned QW   = ppg_hrd_pkg::Q_W;
  localparam int unsigned AW   = ppg_hrd_pkg::ALPHA_W;
  localparam int unsigned FW   = ppg_hrd_pkg::FRAC_W;
  localparam int unsigned DW   = ppg_hrd_pkg::DIFF_W;
  localparam int unsigned LW   = ppg_hrd_pkg::LO_W;
  localparam int unsigned CW   = ppg_hrd_pkg::ACC_W;
  localparam int unsigned SW   = ppg_hrd_pkg::SUM_W;
  localparam int unsigned PW   = CW - FW;
  localparam int unsigned VW   = ppg_hrd_pkg::IVL_W;
  localparam int unsigned NW   = ppg_hrd_pkg::NUM_W;
  localparam int unsigned RW   = ppg_hrd_pkg::RATE_W;
  localparam int unsigned XW   = ppg_hrd_pkg::IDX_W;
  localparam int unsigned SCW  = QW + FW;
  localparam int unsigned RI_W = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;
  localparam int unsigned RC_W = $clog2(INTERVAL_DEPTH + 1);

  // configuration
  logic [AW-1:0] dc_alpha_q, fast_alpha_q, slow_alpha_q, smooth_alpha_q, noise_alpha_q;
  logic [VW-1:0] ivl_min_q, ivl_max_q;
  logic [NW-1:0] beats_num_q;

  // filter state
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [QW-1:0] dc_q, fast_q, slow_q, prev_q, prev2_q, noise_q, y_q, ac_q, bp_q;
  logic [DW-1:0] diff_q;
  logic [CW-1:0] acc_q;

  // beat state
  logic [XW-1:0]   last_q, idx_q;
  logic [VW-1:0]   ring_q [INTERVAL_DEPTH];
  logic [RI_W-1:0] head_q, i_q, j_q;
  logic [RC_W-1:0] count_q, lt_q, le_q;
  logic [VW-1:0]   cand_q, med_q;
  logic            peak_q, beat_q;
  logic [RW-1:0]   rate_q;

  // output register
  logic            out_valid_q;
  logic [QW-1:0]   out_level_q;
  logic [RW-1:0]   out_rate_q;
  logic            out_peak_q, out_beat_q;

  // operand selection
  logic [QW-1:0] x_op, t_op, v_in;
  logic [AW-1:0] alpha_op;
  logic [SCW-1:0] scaled;

  assign scaled = {{(QW - SAMPLE_BITS){1'b0}}, sample_q, {FW{1'b0}}};
  assign v_in   = (|scaled[SCW-1:QW-1]) ? ppg_hrd_pkg::Q_POS_MAX : scaled[QW-1:0];

  always_comb begin
    case (cmd_i.sel)
      ppg_hrd_pkg::EMA_DC: begin
        x_op = dc_q;      t_op = v_in;  alpha_op = dc_alpha_q;
      end
      ppg_hrd_pkg::EMA_FAST: begin
        x_op = fast_q;    t_op = ac_q;  alpha_op = fast_alpha_q;
      end
      ppg_hrd_pkg::EMA_SLOW: begin
        x_op = slow_q;    t_op = ac_q;  alpha_op = slow_alpha_q;
      end
      ppg_hrd_pkg::EMA_SMOOTH: begin
        x_op = prev_q;    t_op = bp_q;  alpha_op = smooth_alpha_q;
      end
      ppg_hrd_pkg::EMA_NOISE: begin
        x_op = noise_q;   t_op = y_q;   alpha_op = noise_alpha_q;
      end
      default: begin
        x_op = dc_q;      t_op = v_in;  alpha_op = dc_alpha_q;
      end
    endcase
  end

  // EMA unit arithmetic, one step per command
  logic [DW-1:0]        diff_d;
  logic [LW+AW-1:0]     p_lo;
  logic signed [DW-1:0] p_hi;
  logic [CW-1:0]        acc_hi;
  logic [PW-1:0]        prod;
  logic [QW-1:0]        ema_res, ac_res, bp_res;

  assign diff_d  = {t_op[QW-1], t_op} - {x_op[QW-1], x_op};
  assign p_lo    = diff_q[LW-1:0] * alpha_op;
  assign p_hi    = $signed(diff_q[DW-1:LW]) * $signed({1'b0, alpha_op});
  assign acc_hi  = acc_q + {p_hi, {LW{1'b0}}};
  assign prod    = acc_q[CW-1:FW];
  assign ema_res = ppg_hrd_pkg::sat48($signed({{(SW-QW){x_op[QW-1]}}, x_op})
                                      + $signed({{(SW-PW){prod[PW-1]}}, prod}));
  assign ac_res  = ppg_hrd_pkg::sat48($signed({{(SW-QW){v_in[QW-1]}}, v_in})
                                      - $signed({{(SW-QW){dc_q[QW-1]}}, dc_q}));
  assign bp_res  = ppg_hrd_pkg::sat48($signed({{(SW-QW){fast_q[QW-1]}}, fast_q})
                                      - $signed({{(SW-QW){slow_q[QW-1]}}, slow_q}));

  // peak test on the previous smoothed value
  logic [QW:0]   mag;
  logic          peak, first_peak, ge_min, in_win, beat;
  logic [XW-1:0] ibi;

  assign mag        = prev_q[QW-1] ? ({1'b0, ~prev_q} + 1'b1) : {1'b0, prev_q};
  assign peak       = ($signed(prev_q) > $signed(prev2_q)) && ($signed(prev_q) > $signed(y_q))
                      && ($signed(mag) > $signed({noise_q[QW-1], noise_q}));
  assign first_peak = (last_q == '0);
  assign ibi        = idx_q - last_q;
  assign ge_min     = ibi >= XW'(ivl_min_q);
  assign in_win     = ge_min && (ibi <= XW'(ivl_max_q));
  assign beat       = peak && !first_peak && in_win;

  // median scan
  logic [VW-1:0]   scan_val;
  logic [RC_W-1:0] k_rank;

  assign scan_val = ring_q[j_q];
  assign k_rank   = count_q >> 1;

  // divider
  logic          div_start, div_done;
  logic [NW-1:0] quotient;

  assign div_start = (cmd_i.op == ppg_hrd_pkg::CMD_DIV) && (med_q != '0);

  ppg_hrd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (beats_num_q),
    .divisor_i  (med_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_alpha_q     <= ppg_hrd_pkg::DC_ALPHA_RST;
      fast_alpha_q   <= ppg_hrd_pkg::FAST_ALPHA_RST;
      slow_alpha_q   <= ppg_hrd_pkg::SLOW_ALPHA_RST;
      smooth_alpha_q <= ppg_hrd_pkg::SMOOTH_ALPHA_RST;
      noise_alpha_q  <= ppg_hrd_pkg::NOISE_ALPHA_RST;
      ivl_min_q      <= ppg_hrd_pkg::IVL_MIN_RST;
      ivl_max_q      <= ppg_hrd_pkg::IVL_MAX_RST;
      beats_num_q    <= ppg_hrd_pkg::BEATS_NUM_RST;
    end else if (cfg_we_i) begin
      case (ppg_hrd_pkg::cfg_idx_e'(cfg_index_i))
        ppg_hrd_pkg::CFG_DC_ALPHA:     dc_alpha_q     <= cfg_data_i[AW-1:0];
        ppg_hrd_pkg::CFG_FAST_ALPHA:   fast_alpha_q   <= cfg_data_i[AW-1:0];
        ppg_hrd_pkg::CFG_SLOW_ALPHA:   slow_alpha_q   <= cfg_data_i[AW-1:0];
        ppg_hrd_pkg::CFG_SMOOTH_ALPHA: smooth_alpha_q <= cfg_data_i[AW-1:0];
        ppg_hrd_pkg::CFG_NOISE_ALPHA:  noise_alpha_q  <= cfg_data_i[AW-1:0];
        ppg_hrd_pkg::CFG_IVL_MIN:      ivl_min_q      <= cfg_data_i[VW-1:0];
        ppg_hrd_pkg::CFG_IVL_MAX:      ivl_max_q      <= cfg_data_i[VW-1:0];
        ppg_hrd_pkg::CFG_BEATS_NUM:    beats_num_q    <= cfg_data_i[NW-1:0];
        default: ;
      endcase
    end
  end

  // filter and beat state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q    <= '0;
      fast_q  <= '0;
      slow_q  <= '0;
      prev_q  <= '0;
      prev2_q <= '0;
      noise_q <= ppg_hrd_pkg::NOISE_RST;
      last_q  <= '0;
      idx_q   <= '0;
      head_q  <= '0;
      count_q <= '0;
      rate_q  <= '0;
      peak_q  <= 1'b0;
      beat_q  <= 1'b0;
      for (int n = 0; n < INTERVAL_DEPTH; n++) begin
        ring_q[n] <= '0;
      end
    end else begin
      case (cmd_i.op)
        ppg_hrd_pkg::CMD_WB: begin
          case (cmd_i.sel)
            ppg_hrd_pkg::EMA_DC:     dc_q    <= ema_res;
            ppg_hrd_pkg::EMA_FAST:   fast_q  <= ema_res;
            ppg_hrd_pkg::EMA_SLOW:   slow_q  <= ema_res;
            ppg_hrd_pkg::EMA_NOISE:  noise_q <= ema_res;
            default: ;
          endcase
        end
        ppg_hrd_pkg::CMD_PEAK: begin
          peak_q  <= peak;
          beat_q  <= beat;
          prev2_q <= prev_q;
          prev_q  <= y_q;
          idx_q   <= idx_q + 1'b1;
          if (peak) begin
            if (first_peak || ge_min) begin
              last_q <= idx_q;
            end
            if (beat) begin
              ring_q[head_q] <= ibi[VW-1:0];
              head_q <= (head_q == RI_W'(INTERVAL_DEPTH - 1)) ? '0 : head_q + 1'b1;
              if (count_q != RC_W'(INTERVAL_DEPTH)) begin
                count_q <= count_q + 1'b1;
              end
            end
          end
        end
        ppg_hrd_pkg::CMD_DIV: begin
          if (med_q == '0) begin
            rate_q <= ppg_hrd_pkg::RATE_MAX;
          end
        end
        default: ;
      endcase
      if (div_done) begin
        rate_q <= (quotient > NW'(ppg_hrd_pkg::RATE_MAX)) ? ppg_hrd_pkg::RATE_MAX
                                                          : quotient[RW-1:0];
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ppg_hrd_pkg::CMD_LOAD: sample_q <= sample_i;
      ppg_hrd_pkg::CMD_DIFF: diff_q   <= diff_d;
      ppg_hrd_pkg::CMD_MLO:  acc_q    <= CW'(p_lo);
      ppg_hrd_pkg::CMD_MHI:  acc_q    <= acc_hi;
      ppg_hrd_pkg::CMD_WB: begin
        if (cmd_i.sel == ppg_hrd_pkg::EMA_SMOOTH) begin
          y_q <= ema_res;
        end
      end
      ppg_hrd_pkg::CMD_AC:   ac_q <= ac_res;
      ppg_hrd_pkg::CMD_BP:   bp_q <= bp_res;
      ppg_hrd_pkg::CMD_PEAK: i_q  <= '0;
      ppg_hrd_pkg::CMD_CAND: begin
        cand_q <= ring_q[i_q];
        j_q    <= '0;
        lt_q   <= '0;
        le_q   <= '0;
      end
      ppg_hrd_pkg::CMD_CMP: begin
        lt_q <= lt_q + RC_W'(scan_val < cand_q);
        le_q <= le_q + RC_W'(scan_val <= cand_q);
        j_q  <= j_q + 1'b1;
      end
      ppg_hrd_pkg::CMD_CHECK: begin
        if (status_o.found) begin
          med_q <= cand_q;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register, refilled while the old result drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == ppg_hrd_pkg::CMD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ppg_hrd_pkg::CMD_OUT) begin
      out_level_q <= y_q;
      out_rate_q  <= rate_q;
      out_peak_q  <= peak_q;
      out_beat_q  <= beat_q;
    end
  end

  assign status_o.beat     = beat;
  assign status_o.j_last   = (RC_W'(j_q) == count_q - 1'b1);
  assign status_o.found    = (lt_q <= k_rank) && (k_rank < le_q);
  assign status_o.med_zero = (med_q == '0);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(ppg_hrd_pkg::OUT_W - QW - RW){1'b0}}, out_level_q, out_rate_q};
  assign m_tuser_o  = {out_beat_q, out_peak_q};

endmodule

[rtl/ppg_hrd_ctrl.sv]
// ----------------------------------------------------------------------------
// ppg_hrd_ctrl
// Sequencer: steps one sample through the EMA unit, peak test, median scan
// and divider.
// ----------------------------------------------------------------------------
module ppg_hrd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ppg_hrd_pkg::status_t status_i,
  output ppg_hrd_pkg::cmd_t    cmd_o
);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_DIFF  = 14'b00000000000010,
    ST_MLO   = 14'b00000000000100,
    ST_MHI   = 14'b00000000001000,
    ST_WB    = 14'b00000000010000,
    ST_AC    = 14'b00000000100000,
    ST_BP    = 14'b00000001000000,
    ST_PEAK  = 14'b00000010000000,
    ST_CAND  = 14'b00000100000000,
    ST_CMP   = 14'b00001000000000,
    ST_CHECK = 14'b00010000000000,
    ST_DIV   = 14'b00100000000000,
    ST_DIVW  = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_e;

  state_e                state_q, state_d;
  ppg_hrd_pkg::ema_sel_e sel_q, sel_d;

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o.op   = ppg_hrd_pkg::CMD_NONE;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ppg_hrd_pkg::CMD_LOAD;
          sel_d    = ppg_hrd_pkg::EMA_DC;
          state_d  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.op = ppg_hrd_pkg::CMD_DIFF;
        state_d  = ST_MLO;
      end
      ST_MLO: begin
        cmd_o.op = ppg_hrd_pkg::CMD_MLO;
        state_d  = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.op = ppg_hrd_pkg::CMD_MHI;
        state_d  = ST_WB;
      end
      ST_WB: begin
        cmd_o.op = ppg_hrd_pkg::CMD_WB;
        case (sel_q)
          ppg_hrd_pkg::EMA_DC:     state_d = ST_AC;
          ppg_hrd_pkg::EMA_FAST: begin
            sel_d   = ppg_hrd_pkg::EMA_SLOW;
            state_d = ST_DIFF;
          end
          ppg_hrd_pkg::EMA_SLOW:   state_d = ST_BP;
          ppg_hrd_pkg::EMA_SMOOTH: begin
            sel_d   = ppg_hrd_pkg::EMA_NOISE;
            state_d = ST_DIFF;
          end
          default:                 state_d = ST_PEAK;
        endcase
      end
      ST_AC: begin
        cmd_o.op = ppg_hrd_pkg::CMD_AC;
        sel_d    = ppg_hrd_pkg::EMA_FAST;
        state_d  = ST_DIFF;
      end
      ST_BP: begin
        cmd_o.op = ppg_hrd_pkg::CMD_BP;
        sel_d    = ppg_hrd_pkg::EMA_SMOOTH;
        state_d  = ST_DIFF;
      end
      ST_PEAK: begin
        cmd_o.op = ppg_hrd_pkg::CMD_PEAK;
        state_d  = status_i.beat ? ST_CAND : ST_DONE;
      end
      ST_CAND: begin
        cmd_o.op = ppg_hrd_pkg::CMD_CAND;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.op = ppg_hrd_pkg::CMD_CMP;
        if (status_i.j_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.op = ppg_hrd_pkg::CMD_CHECK;
        state_d  = status_i.found ? ST_DIV : ST_CAND;
      end
      ST_DIV: begin
        cmd_o.op = ppg_hrd_pkg::CMD_DIV;
        state_d  = status_i.med_zero ? ST_DONE : ST_DIVW;
      end
      ST_DIVW: begin
        if (status_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = ppg_hrd_pkg::CMD_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= ppg_hrd_pkg::EMA_DC;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

[sim/ppg_hrd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_hrd_checker
// Watches the sample, result and configuration channels of the heart-rate
// detector, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module ppg_hrd_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [ppg_hrd_pkg::OUT_W-1:0]       m_axis_tdata,
  input  logic [ppg_hrd_pkg::USER_W-1:0]      m_axis_tuser,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_o,
  input  logic [ppg_hrd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ppg_hrd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                                  fail_cnt_o,
  output int                                  pending_o,
  output int                                  peak_cnt_o,
  output int                                  beat_cnt_o
);

  localparam longint QMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint QMIN = -64'sh8000_0000_0000;

  typedef struct packed {
    logic             peak;
    logic             beat;
    logic [9:0]       rate;
    logic [47:0]      level;
  } hr_result_t;

  hr_result_t    result_q[$];

  logic [23:0]   a_dc, a_fast, a_slow, a_smooth, a_noise;
  logic [11:0]   ivl_lo, ivl_hi;
  logic [17:0]   beats_num;
  longint        dc_lvl, fast_lvl, slow_lvl, smooth_d1, smooth_d2, noise_lvl;
  logic [31:0]   last_peak, smp_count;
  logic [11:0]   ivl_ring [8];
  int unsigned   ring_wr, ring_fill;
  logic [9:0]    rate_q;

  function automatic longint clamp48(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  // x + floor((t - x) * alpha / 2^24), saturated
  function automatic longint ema_step(input longint x, input longint t, input logic [23:0] a);
    logic signed [95:0] prod;
    prod = 96'(t - x) * $signed({72'd0, a});
    return clamp48(x + longint'(prod >>> 24));
  endfunction

  function automatic hr_result_t heart_step(input logic [17:0] raw);
    hr_result_t  r;
    longint      v, ac, bp, y, mag;
    logic [31:0] ibi;
    logic [11:0] srt [8];
    logic [11:0] key;
    logic [11:0] med;
    logic [31:0] quo;
    int          b;
    v = longint'(raw) <<< 24;
    r.beat = 1'b0;
    dc_lvl    = ema_step(dc_lvl, v, a_dc);
    ac        = clamp48(v - dc_lvl);
    fast_lvl  = ema_step(fast_lvl, ac, a_fast);
    slow_lvl  = ema_step(slow_lvl, ac, a_slow);
    bp        = clamp48(fast_lvl - slow_lvl);
    y         = ema_step(smooth_d1, bp, a_smooth);
    noise_lvl = ema_step(noise_lvl, y, a_noise);
    mag = smooth_d1 < 0 ? -smooth_d1 : smooth_d1;
    r.peak = (smooth_d1 > smooth_d2) && (smooth_d1 > y) && (mag > noise_lvl);
    if (r.peak) begin
      if (last_peak == 0) begin
        last_peak = smp_count;
      end else begin
        ibi = smp_count - last_peak;
        if (ibi >= ivl_lo && ibi <= ivl_hi) begin
          last_peak = smp_count;
          ivl_ring[ring_wr] = ibi[11:0];
          ring_wr = (ring_wr + 1) % 8;
          if (ring_fill < 8) ring_fill++;
          for (int i = 0; i < 8; i++) srt[i] = ivl_ring[i];
          for (int i = 1; i < ring_fill; i++) begin
            key = srt[i];
            b = i;
            while (b > 0 && srt[b-1] > key) begin
              srt[b] = srt[b-1];
              b--;
            end
            srt[b] = key;
          end
          med = srt[(ring_fill / 2) % 8];
          if (med == 0) begin
            rate_q = ppg_hrd_pkg::RATE_MAX;
          end else begin
            quo = 32'(beats_num) / 32'(med);
            rate_q = (quo > 32'(ppg_hrd_pkg::RATE_MAX)) ? ppg_hrd_pkg::RATE_MAX : quo[9:0];
          end
          r.beat = 1'b1;
        end else if (ibi >= ivl_lo) begin
          last_peak = smp_count;
        end
      end
    end
    smooth_d2 = smooth_d1;
    smooth_d1 = y;
    smp_count++;
    r.rate  = rate_q;
    r.level = y[47:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hr_result_t got, exp_r;
    if (!rst_ni) begin
      a_dc = ppg_hrd_pkg::DC_ALPHA_RST;
      a_fast = ppg_hrd_pkg::FAST_ALPHA_RST;
      a_slow = ppg_hrd_pkg::SLOW_ALPHA_RST;
      a_smooth = ppg_hrd_pkg::SMOOTH_ALPHA_RST;
      a_noise = ppg_hrd_pkg::NOISE_ALPHA_RST;
      ivl_lo = ppg_hrd_pkg::IVL_MIN_RST;
      ivl_hi = ppg_hrd_pkg::IVL_MAX_RST;
      beats_num = ppg_hrd_pkg::BEATS_NUM_RST;
      dc_lvl = 0; fast_lvl = 0; slow_lvl = 0; smooth_d1 = 0; smooth_d2 = 0;
      noise_lvl = longint'(1) <<< 24;
      last_peak = '0; smp_count = '0; ring_wr = 0; ring_fill = 0; rate_q = '0;
      for (int i = 0; i < 8; i++) ivl_ring[i] = '0;
      result_q.delete();
      fail_cnt_o = 0; peak_cnt_o = 0; beat_cnt_o = 0;
    end else begin
      // results first: a result never belongs to a request of the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.peak  = m_axis_tuser[0];
        got.beat  = m_axis_tuser[1];
        got.rate  = m_axis_tdata[9:0];
        got.level = m_axis_tdata[57:10];
        if (result_q.size() == 0) begin
          $error("unexpected result: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          fail_cnt_o++;
        end else begin
          exp_r = result_q.pop_front();
          if (got.peak != exp_r.peak) begin
            $error("peak_seen: expected %0d, actual %0d", exp_r.peak, got.peak);
            fail_cnt_o++;
          end
          if (got.beat != exp_r.beat) begin
            $error("beat_valid: expected %0d, actual %0d", exp_r.beat, got.beat);
            fail_cnt_o++;
          end
          if (got.rate != exp_r.rate) begin
            $error("rate_bpm: expected %0d, actual %0d", exp_r.rate, got.rate);
            fail_cnt_o++;
          end
          if (got.level != exp_r.level) begin
            $error("smoothed_level: expected %h, actual %h", exp_r.level, got.level);
            fail_cnt_o++;
          end
          peak_cnt_o += int'(got.peak);
          beat_cnt_o += int'(got.beat);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(heart_step(s_axis_tdata[17:0]));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (ppg_hrd_pkg::cfg_idx_e'(cfg_index_i))
          ppg_hrd_pkg::CFG_DC_ALPHA:     a_dc = cfg_data_i;
          ppg_hrd_pkg::CFG_FAST_ALPHA:   a_fast = cfg_data_i;
          ppg_hrd_pkg::CFG_SLOW_ALPHA:   a_slow = cfg_data_i;
          ppg_hrd_pkg::CFG_SMOOTH_ALPHA: a_smooth = cfg_data_i;
          ppg_hrd_pkg::CFG_NOISE_ALPHA:  a_noise = cfg_data_i;
          ppg_hrd_pkg::CFG_IVL_MIN:      ivl_lo = cfg_data_i[11:0];
          ppg_hrd_pkg::CFG_IVL_MAX:      ivl_hi = cfg_data_i[11:0];
          ppg_hrd_pkg::CFG_BEATS_NUM:    beats_num = cfg_data_i[17:0];
          default: ;
        endcase
      end
    end
    pending_o = result_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples and configuration into the heart-rate detector with bursty
// traffic and a stalling result sink; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [23:0]                         s_axis_tdata;    // [17:0] ir_sample
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [ppg_hrd_pkg::OUT_W-1:0]       m_axis_tdata;    // [9:0] rate_bpm,
                                                        // [57:10] smoothed_level
  logic [ppg_hrd_pkg::USER_W-1:0]      m_axis_tuser;    // [0] peak_seen, [1] beat_valid
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [ppg_hrd_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [ppg_hrd_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  int fail_cnt, pending, peak_cnt, beat_cnt;
  int burst_left;
  int sent;
  int sink_mode, sink_left;

  ppg_heart_rate_detector u_top (.*);

  ppg_hrd_checker u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .peak_cnt_o(peak_cnt), .beat_cnt_o(beat_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result sink: always ready, random, or mostly stalled, switching modes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_mode = 0;
      sink_left = 0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = $urandom_range(0, 2);
        sink_left = $urandom_range(20, 200);
      end
      sink_left--;
      case (sink_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one sample request; bursts of random length with random gaps between
  task automatic send_sample(input logic [17:0] smp);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, smp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  // registers are only written once every result is back; waiting for an edge
  // first lets the checker count a request taken on the edge just seen
  task automatic write_reg(input ppg_hrd_pkg::cfg_idx_e idx, input logic [23:0] val);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [23:0] dc, fa, sl, sm, nz,
                          input logic [11:0] lo, hi, input logic [17:0] num);
    write_reg(ppg_hrd_pkg::CFG_DC_ALPHA, dc);
    write_reg(ppg_hrd_pkg::CFG_FAST_ALPHA, fa);
    write_reg(ppg_hrd_pkg::CFG_SLOW_ALPHA, sl);
    write_reg(ppg_hrd_pkg::CFG_SMOOTH_ALPHA, sm);
    write_reg(ppg_hrd_pkg::CFG_NOISE_ALPHA, nz);
    write_reg(ppg_hrd_pkg::CFG_IVL_MIN, 24'(lo));
    write_reg(ppg_hrd_pkg::CFG_IVL_MAX, 24'(hi));
    write_reg(ppg_hrd_pkg::CFG_BEATS_NUM, 24'(num));
  endtask

  // pulse-like waveform: triangle with random period, amplitude and noise;
  // a few samples are pure noise, random over the full sample range
  task automatic pulse_train(input int n, input int p_lo, input int p_hi);
    int   per, amp, base, ph, v;
    per  = $urandom_range(p_lo, p_hi);
    amp  = $urandom_range(500, 60000);
    base = $urandom_range(20000, 150000);
    ph   = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        v = $urandom_range(0, 262143);
      end else begin
        v = (ph < per / 2) ? base + amp * ph / (per / 2 + 1)
                           : base + amp * (per - ph) / (per / 2 + 1);
        v += $urandom_range(0, amp / 16 + 1);
      end
      if (v > 262143) v = 262143;
      send_sample(v[17:0]);
      ph++;
      if (ph >= per) begin
        ph = 0;
        if ($urandom_range(0, 7) == 0) per = $urandom_range(p_lo, p_hi);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = ppg_hrd_pkg::CFG_DC_ALPHA;
    cfg_data_i    = '0;
    burst_left    = 0;
    sent          = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: sample extremes and steps under reset coefficients
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 18'h3FFFF : 18'h0);
    for (int i = 0; i < 6; i++) send_sample(18'h3FFFF);
    for (int i = 0; i < 6; i++) send_sample(18'h0);
    send_sample(18'h2AAAA);
    send_sample(18'h15555);

    // all coefficients at full scale, widest window, largest numerator
    set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
             12'd1, 12'd4095, 18'h3FFFF);
    pulse_train(90, 3, 12);

    // frozen filters, narrowest window at the top, numerator of one
    set_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 12'd4095, 12'd4095, 18'd1);
    pulse_train(30, 3, 12);

    // quick filters, short beats: the ring fills and wraps
    set_regs(24'h100000, 24'h600000, 24'h020000, 24'hA00000, 24'h080000,
             12'd6, 12'd40, 18'd6000);
    pulse_train(160, 8, 30);

    // reset-like coefficients with max below min, then a normal window
    set_regs(24'd838861, 24'd671089, 24'd168, 24'd1677722, 24'd838861,
             12'd50, 12'd20, 18'd100);
    pulse_train(30, 10, 40);
    set_regs(24'h200000, 24'h500000, 24'h008000, 24'h600000, 24'h040000,
             12'd4, 12'd25, 18'd1200);
    pulse_train(120, 6, 20);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    fork
      while (pending != 0) @(posedge clk_i);
      repeat (20000) @(posedge clk_i);
    join_any
    disable fork;
    repeat (200) @(posedge clk_i);

    $display("Covered %0d samples over six coefficient/window settings,", sent);
    $display("with %0d peaks and %0d accepted beat intervals.", peak_cnt, beat_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
